// ----- rtl/text_console_writer_defines.svh -----
// assertion helpers used by the console rtl
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define TCW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// consequence checked in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int INDEX_W = 11;
	localparam int CELL_W  = 16;
	localparam int COLOR_W = 4;
	localparam int REG_W   = 1;

	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [REG_W-1:0] REG_BACK_COLOR = 1'd0;
	localparam logic [REG_W-1:0] REG_FORE_COLOR = 1'd1;

	localparam logic [COLOR_W-1:0] BACK_RESET = 4'h0;
	localparam logic [COLOR_W-1:0] FORE_RESET = 4'hF;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

	localparam int TAB_STOP = 8;

	localparam logic [CELL_W-1:0] RESET_BLANK = {BACK_RESET, FORE_RESET, CH_SPACE};

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_FILL,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/tcw_if.sv -----
interface tcw_req_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::CMD_W-1:0]    cmd;
	logic [tcw_pkg::CHAR_W-1:0]   char_code;
	logic [tcw_pkg::INDEX_W-1:0]  cell_index;

	modport source (output valid, output cmd, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input cmd, input char_code, input cell_index,
		output ready);
endinterface

interface tcw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::INDEX_W-1:0]  cursor_index;
	logic [tcw_pkg::CELL_W-1:0]   cell_data;

	modport source (output valid, output cursor_index, output cell_data, input ready);
	modport sink (input valid, input cursor_index, input cell_data, output ready);
endinterface

interface tcw_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::REG_W-1:0]    index;
	logic [tcw_pkg::COLOR_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tcw_screen_ram.sv -----
module tcw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [tcw_pkg::CELL_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [tcw_pkg::CELL_W-1:0] rd_data
);

	logic [tcw_pkg::CELL_W-1:0] mem_q [DEPTH];
	logic [tcw_pkg::CELL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/text_console_writer.sv -----
// Text console over a ROWS x COLUMNS store of 16-bit cells (attribute high byte, character
// low byte) kept in one single-port-write, registered-read memory; a small sequencer walks
// it one cell per step through a shared address counter. Each request returns one response
// holding the linear cursor index and, for a read, the cell. A put is executed in ST_EXEC,
// a read passes ST_EXEC then ST_READ (registered memory read), a clear blanks every cell in
// ST_FILL. A put that scrolls copies each row below the top up one row, a cell at a time
// (memory read in ST_SCR_RD, then write in ST_SCR_WR) and blanks the bottom row. The
// request channel is not ready while a request is in progress. After reset the store is
// blanked with attribute 0x0F before the first request is taken; color register writes
// are taken at any time.
`include "text_console_writer_defines.svh"

module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	tcw_req_if.sink    req,
	tcw_rsp_if.source  rsp,
	tcw_cfg_if.sink    cfg
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);

	localparam logic [AW-1:0] LAST_CELL  = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] LAST_COPY  = AW'(CELL_COUNT - COLUMNS - 1);
	localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);
	localparam logic [AW-1:0] BOTTOM_LIN = AW'((ROWS - 1) * COLUMNS);
	localparam logic [CW:0]   COL_LIMIT  = (CW+1)'(COLUMNS);
	localparam logic [CW:0]   TAB_ADD    = (CW+1)'(tcw_pkg::TAB_STOP);
	localparam logic [CW:0]   TAB_MASK   = (CW+1)'(tcw_pkg::TAB_STOP - 1);
	localparam logic [RW:0]   ROW_LIMIT  = (RW+1)'(ROWS);
	localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

	tcw_pkg::state_t state_q, state_d;

	logic [tcw_pkg::COLOR_W-1:0] back_q, fore_q;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [AW-1:0] lin_q, lin_d;
	logic [AW-1:0] ptr_q, ptr_d;

	logic [tcw_pkg::CMD_W-1:0]   cmd_q;
	logic [tcw_pkg::CHAR_W-1:0]  char_q;
	logic [tcw_pkg::INDEX_W-1:0] idx_q;
	logic                        in_range_q;

	logic                        out_valid_q;
	logic [tcw_pkg::INDEX_W-1:0] out_cursor_q;
	logic [tcw_pkg::CELL_W-1:0]  out_data_q;

	logic                        wr_en, rd_en;
	logic [AW-1:0]               wr_addr, rd_addr;
	logic [tcw_pkg::CELL_W-1:0]  wr_data, rd_data, blank_cur, fin_data;
	logic                        take, fin, slot_free;

	// put decode
	logic          printable, row_inc, wrap, scroll;
	logic [CW:0]   col_x;
	logic [CW-1:0] col_n;
	logic [RW:0]   row_x;
	logic [RW-1:0] row_n;
	logic [AW-1:0] lin_n;

	tcw_screen_ram #(
		.DEPTH (CELL_COUNT),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_q <= tcw_pkg::BACK_RESET;
			fore_q <= tcw_pkg::FORE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				tcw_pkg::REG_BACK_COLOR: back_q <= cfg.data;
				tcw_pkg::REG_FORE_COLOR: fore_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign blank_cur = {back_q, fore_q, tcw_pkg::CH_SPACE};
	assign printable = char_q inside {[tcw_pkg::CH_SPACE:tcw_pkg::CH_LAST]};

	always_comb begin
		col_x   = {1'b0, col_q};
		row_inc = 1'b0;
		case (char_q)
			tcw_pkg::CH_BS: begin
				if (col_q != '0) begin
					col_x = col_x - (CW+1)'(1);
				end
			end
			tcw_pkg::CH_TAB: col_x = (col_x + TAB_ADD) & ~TAB_MASK;
			tcw_pkg::CH_CR:  col_x = '0;
			tcw_pkg::CH_LF: begin
				col_x   = '0;
				row_inc = 1'b1;
			end
			default: begin
				if (printable) begin
					col_x = col_x + (CW+1)'(1);
				end
			end
		endcase
		wrap = col_x >= COL_LIMIT;
		if (wrap) begin
			row_inc = 1'b1;
		end
		col_n  = wrap ? '0 : col_x[CW-1:0];
		row_x  = {1'b0, row_q} + (RW+1)'(row_inc);
		scroll = row_x >= ROW_LIMIT;
		row_n  = scroll ? LAST_ROW : row_x[RW-1:0];
		// linear cursor follows the column and row moves, no multiply needed
		lin_n  = scroll ? BOTTOM_LIN
			: lin_q - AW'(col_q) + AW'(col_n) + (row_inc ? ROW_STRIDE : '0);
	end

	assign slot_free = !out_valid_q || rsp.ready;
	assign fin_data  = (cmd_q == tcw_pkg::CMD_READ && in_range_q) ? rd_data : '0;
	assign req.ready = take;

	always_comb begin
		state_d = state_q;
		ptr_d   = ptr_q;
		col_d   = col_q;
		row_d   = row_q;
		lin_d   = lin_q;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = blank_cur;
		rd_en   = 1'b0;
		rd_addr = ptr_q + ROW_STRIDE;
		take    = 1'b0;
		fin     = 1'b0;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				wr_en   = 1'b1;
				wr_data = tcw_pkg::RESET_BLANK;
				if (ptr_q == LAST_CELL) begin
					ptr_d   = '0;
					state_d = tcw_pkg::ST_IDLE;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			tcw_pkg::ST_IDLE: begin
				take = 1'b1;
				if (req.valid) begin
					state_d = tcw_pkg::ST_EXEC;
				end
			end
			tcw_pkg::ST_EXEC: begin
				case (cmd_q)
					tcw_pkg::CMD_PUT: begin
						col_d = col_n;
						row_d = row_n;
						lin_d = lin_n;
						if (printable) begin
							wr_en   = 1'b1;
							wr_addr = lin_q;
							wr_data = {back_q, fore_q, char_q};
						end
						if (scroll) begin
							ptr_d   = '0;
							state_d = tcw_pkg::ST_SCR_RD;
						end else begin
							fin     = slot_free;
							state_d = slot_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
						end
					end
					tcw_pkg::CMD_CLEAR: begin
						col_d   = '0;
						row_d   = '0;
						lin_d   = '0;
						ptr_d   = '0;
						state_d = tcw_pkg::ST_FILL;
					end
					tcw_pkg::CMD_READ: begin
						rd_en   = in_range_q;
						rd_addr = AW'(idx_q);
						state_d = tcw_pkg::ST_READ;
					end
					default: begin
						fin     = slot_free;
						state_d = slot_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
					end
				endcase
			end
			tcw_pkg::ST_READ: begin
				fin     = slot_free;
				state_d = slot_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_SCR_RD: begin
				rd_en   = 1'b1;
				state_d = tcw_pkg::ST_SCR_WR;
			end
			tcw_pkg::ST_SCR_WR: begin
				wr_en   = 1'b1;
				wr_data = rd_data;
				ptr_d   = ptr_q + AW'(1);
				state_d = (ptr_q == LAST_COPY) ? tcw_pkg::ST_FILL : tcw_pkg::ST_SCR_RD;
			end
			tcw_pkg::ST_FILL: begin
				wr_en = 1'b1;
				if (ptr_q == LAST_CELL) begin
					ptr_d   = '0;
					fin     = slot_free;
					state_d = slot_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			tcw_pkg::ST_DONE: begin
				if (slot_free) begin
					fin     = 1'b1;
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			default: state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
			ptr_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			lin_q   <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			col_q   <= col_d;
			row_q   <= row_d;
			lin_q   <= lin_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= tcw_pkg::CMD_PUT;
		end else if (take && req.valid) begin
			cmd_q <= req.cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (take && req.valid) begin
			char_q     <= req.char_code;
			idx_q      <= req.cell_index;
			in_range_q <= int'(req.cell_index) < CELL_COUNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_cursor_q <= tcw_pkg::INDEX_W'(lin_d);
			out_data_q   <= fin_data;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.cursor_index = out_cursor_q;
	assign rsp.cell_data    = out_data_q;

	`TCW_ASSERT(a_lin_range, int'(lin_q) < CELL_COUNT, "cursor index beyond the screen")
	`TCW_ASSERT(a_lin_match, int'(lin_q) == int'(row_q) * COLUMNS + int'(col_q), "linear cursor out of step")
	`TCW_ASSERT_NEXT(a_accept_exec, req.valid && req.ready, state_q == tcw_pkg::ST_EXEC, "accepted request not executed")
	`TCW_ASSERT(a_idle_no_write, state_q == tcw_pkg::ST_IDLE |-> !wr_en, "store written while idle")

endmodule

// ----- dv/text_console_writer_tb.sv -----
module text_console_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCREEN_COLS    = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int CELL_COUNT     = SCREEN_COLS * SCREEN_ROWS;
	localparam int INDEX_TOP      = (1 << tcw_pkg::INDEX_W) - 1;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_ITEMS    = 220;
	localparam int SCROLL_ITEMS   = 150;

	// the block leaves command 3 unused
	localparam logic [tcw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [tcw_pkg::INDEX_W-1:0] cursor_index;
		logic [tcw_pkg::CELL_W-1:0]  cell_data;
	} console_reply_t;

	logic clk;
	logic arst_n;

	tcw_req_if req_ch();
	tcw_rsp_if rsp_ch();
	tcw_cfg_if cfg_ch();

	text_console_writer #(
		.COLUMNS(SCREEN_COLS),
		.ROWS   (SCREEN_ROWS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// predicted console state
	logic [tcw_pkg::CELL_W-1:0]  screen_model [CELL_COUNT];
	int                          cursor_col;
	int                          cursor_row;
	logic [tcw_pkg::COLOR_W-1:0] back_model;
	logic [tcw_pkg::COLOR_W-1:0] fore_model;

	console_reply_t pending_replies[$];

	bit steady_flow;
	int error_count;
	int quiet_cycles;
	int stall_left;
	int put_count, clear_count, read_count, unused_count;
	int scroll_count, color_writes, replies_checked;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [tcw_pkg::CELL_W-1:0] blank_cell();
		return {back_model, fore_model, tcw_pkg::CH_SPACE};
	endfunction

	function automatic logic [tcw_pkg::INDEX_W-1:0] cursor_linear();
		return tcw_pkg::INDEX_W'(cursor_row * SCREEN_COLS + cursor_col);
	endfunction

	function automatic void reset_console_model();
		back_model = tcw_pkg::BACK_RESET;
		fore_model = tcw_pkg::FORE_RESET;
		cursor_col = 0;
		cursor_row = 0;
		for (int i = 0; i < CELL_COUNT; i++)
			screen_model[i] = tcw_pkg::RESET_BLANK;
	endfunction

	function automatic void scroll_model();
		for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++)
			screen_model[i] = screen_model[i + SCREEN_COLS];
		for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
			screen_model[i] = blank_cell();
		cursor_row = SCREEN_ROWS - 1;
		scroll_count++;
	endfunction

	function automatic void put_char_model(input logic [tcw_pkg::CHAR_W-1:0] ch);
		case (ch)
			tcw_pkg::CH_BS: begin
				if (cursor_col != 0)
					cursor_col--;
			end
			tcw_pkg::CH_TAB: cursor_col = (cursor_col + tcw_pkg::TAB_STOP) &
				~(tcw_pkg::TAB_STOP - 1);
			tcw_pkg::CH_CR: cursor_col = 0;
			tcw_pkg::CH_LF: begin
				cursor_col = 0;
				cursor_row++;
			end
			default: begin
				if (ch >= tcw_pkg::CH_SPACE && ch <= tcw_pkg::CH_LAST) begin
					screen_model[cursor_row * SCREEN_COLS + cursor_col] =
						{back_model, fore_model, ch};
					cursor_col++;
				end
			end
		endcase
		if (cursor_col >= SCREEN_COLS) begin
			cursor_col = 0;
			cursor_row++;
		end
		if (cursor_row >= SCREEN_ROWS)
			scroll_model();
	endfunction

	function automatic console_reply_t console_step(input logic [tcw_pkg::CMD_W-1:0] cmd,
			input logic [tcw_pkg::CHAR_W-1:0] ch, input logic [tcw_pkg::INDEX_W-1:0] idx);
		console_reply_t reply;
		reply.cell_data = '0;
		case (cmd)
			tcw_pkg::CMD_PUT: put_char_model(ch);
			tcw_pkg::CMD_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					screen_model[i] = blank_cell();
				cursor_col = 0;
				cursor_row = 0;
			end
			tcw_pkg::CMD_READ: begin
				if (idx < CELL_COUNT)
					reply.cell_data = screen_model[idx];
			end
			default: ;
		endcase
		reply.cursor_index = cursor_linear();
		return reply;
	endfunction

	// mostly back-to-back, some short gaps, rare long ones
	function automatic int idle_gap();
		int r;
		r = $urandom_range(99);
		if (steady_flow || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	task automatic send_request(input logic [tcw_pkg::CMD_W-1:0] cmd,
			input logic [tcw_pkg::CHAR_W-1:0] ch, input logic [tcw_pkg::INDEX_W-1:0] idx);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= cmd;
		req_ch.char_code  <= ch;
		req_ch.cell_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		pending_replies.push_back(console_step(cmd, ch, idx));
		case (cmd)
			tcw_pkg::CMD_PUT: put_count++;
			tcw_pkg::CMD_CLEAR: clear_count++;
			tcw_pkg::CMD_READ: read_count++;
			default: unused_count++;
		endcase
	endtask

	task automatic put_char(input logic [tcw_pkg::CHAR_W-1:0] ch);
		send_request(tcw_pkg::CMD_PUT, ch, tcw_pkg::INDEX_W'($urandom_range(INDEX_TOP)));
	endtask

	task automatic read_cell(input logic [tcw_pkg::INDEX_W-1:0] idx);
		send_request(tcw_pkg::CMD_READ, tcw_pkg::CHAR_W'($urandom_range(255)), idx);
	endtask

	task automatic clear_screen();
		send_request(tcw_pkg::CMD_CLEAR, tcw_pkg::CHAR_W'($urandom_range(255)),
			tcw_pkg::INDEX_W'($urandom_range(INDEX_TOP)));
	endtask

	// stop requesting and let every outstanding response come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
	endtask

	task automatic write_color(input logic [tcw_pkg::REG_W-1:0] reg_index,
			input logic [tcw_pkg::COLOR_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= reg_index;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (reg_index == tcw_pkg::REG_BACK_COLOR)
			back_model = value;
		else
			fore_model = value;
		color_writes++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_colors(input logic [tcw_pkg::COLOR_W-1:0] back,
			input logic [tcw_pkg::COLOR_W-1:0] fore);
		wait_drained();
		if ($urandom_range(1)) begin
			write_color(tcw_pkg::REG_BACK_COLOR, back);
			write_color(tcw_pkg::REG_FORE_COLOR, fore);
		end else begin
			write_color(tcw_pkg::REG_FORE_COLOR, fore);
			write_color(tcw_pkg::REG_BACK_COLOR, back);
		end
	endtask

	function automatic logic [tcw_pkg::CHAR_W-1:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 62)
			return tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CH_LAST, tcw_pkg::CH_SPACE));
		if (r < 68)
			return tcw_pkg::CH_LF;
		if (r < 71)
			return tcw_pkg::CH_CR;
		if (r < 75)
			return tcw_pkg::CH_BS;
		if (r < 80)
			return tcw_pkg::CH_TAB;
		if (r < 90)
			return tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CH_SPACE - 1));
		return tcw_pkg::CHAR_W'($urandom_range(255, 128));
	endfunction

	function automatic logic [tcw_pkg::INDEX_W-1:0] pick_read_index();
		int r;
		int here;
		r = $urandom_range(99);
		here = cursor_row * SCREEN_COLS + cursor_col;
		if (r < 30)
			return tcw_pkg::INDEX_W'(here);
		if (r < 50)
			return tcw_pkg::INDEX_W'((here == 0) ? 0 : here - 1);
		if (r < 65)
			return tcw_pkg::INDEX_W'((SCREEN_ROWS - 1) * SCREEN_COLS +
				$urandom_range(SCREEN_COLS - 1));
		if (r < 93)
			return tcw_pkg::INDEX_W'($urandom_range(CELL_COUNT - 1));
		return tcw_pkg::INDEX_W'($urandom_range(INDEX_TOP, CELL_COUNT));
	endfunction

	task automatic test_reset_contents();
		read_cell(tcw_pkg::INDEX_W'(0));
		read_cell(tcw_pkg::INDEX_W'(CELL_COUNT - 1));
		read_cell(tcw_pkg::INDEX_W'(CELL_COUNT));
		read_cell(tcw_pkg::INDEX_W'(INDEX_TOP));
		send_request(CMD_UNUSED, 8'hFF, tcw_pkg::INDEX_W'(INDEX_TOP));
		wait_drained();
	endtask

	task automatic test_control_codes();
		// backspace at column 0 must hold
		put_char(tcw_pkg::CH_BS);
		put_char(tcw_pkg::CH_SPACE);
		put_char(tcw_pkg::CH_LAST);
		put_char(8'h1F);
		put_char(8'h80);
		put_char(8'hFF);
		put_char(8'h00);
		put_char(tcw_pkg::CH_BS);
		put_char(tcw_pkg::CH_TAB);
		put_char(8'h5A);
		put_char(tcw_pkg::CH_CR);
		put_char(tcw_pkg::CH_LF);
		read_cell(tcw_pkg::INDEX_W'(0));
		read_cell(tcw_pkg::INDEX_W'(1));
		read_cell(tcw_pkg::INDEX_W'(tcw_pkg::TAB_STOP));
		clear_screen();
		read_cell(tcw_pkg::INDEX_W'(1));
		wait_drained();
	endtask

	task automatic test_random_text();
		logic [tcw_pkg::COLOR_W-1:0] back_set [5];
		logic [tcw_pkg::COLOR_W-1:0] fore_set [5];
		int r;
		back_set = '{tcw_pkg::BACK_RESET, 4'hF, 4'hF, 4'h0,
			tcw_pkg::COLOR_W'($urandom_range(15))};
		fore_set = '{tcw_pkg::FORE_RESET, 4'h0, 4'hF, 4'h0,
			tcw_pkg::COLOR_W'($urandom_range(15))};
		for (int phase = 0; phase < 5; phase++) begin
			set_colors(back_set[phase], fore_set[phase]);
			steady_flow = (phase == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(999);
				// now and then hold off until the block has answered everything
				if ($urandom_range(99) < 2)
					wait_drained();
				if (r < 700)
					put_char(pick_char());
				else if (r < 985)
					read_cell(pick_read_index());
				else if (r < 989)
					clear_screen();
				else
					send_request(CMD_UNUSED, tcw_pkg::CHAR_W'($urandom_range(255)),
						tcw_pkg::INDEX_W'($urandom_range(INDEX_TOP)));
			end
		end
		steady_flow = 1'b0;
		wait_drained();
	endtask

	task automatic test_scroll();
		int r;
		set_colors(tcw_pkg::COLOR_W'($urandom_range(15)),
			tcw_pkg::COLOR_W'($urandom_range(15)));
		for (int n = 0; n < SCROLL_ITEMS; n++) begin
			r = $urandom_range(99);
			if (r < 30)
				put_char(tcw_pkg::CH_LF);
			else if (r < 75)
				put_char(tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CH_LAST,
					tcw_pkg::CH_SPACE)));
			else
				read_cell(tcw_pkg::INDEX_W'((SCREEN_ROWS - 2) * SCREEN_COLS +
					$urandom_range(2 * SCREEN_COLS - 1)));
		end
		wait_drained();
	endtask

	// response side: random stalls, compare against the oldest prediction
	always @(posedge clk) begin
		int gap;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: response with nothing outstanding, cursor_index %0d cell_data %h",
					$time, rsp_ch.cursor_index, rsp_ch.cell_data);
				error_count++;
			end else begin
				console_reply_t want;
				want = pending_replies.pop_front();
				replies_checked++;
				if (rsp_ch.cursor_index !== want.cursor_index) begin
					$display("%0t: cursor_index mismatch, expected %0d, actual %0d",
						$time, want.cursor_index, rsp_ch.cursor_index);
					error_count++;
				end
				if (rsp_ch.cell_data !== want.cell_data) begin
					$display("%0t: cell_data mismatch, expected %h, actual %h",
						$time, want.cell_data, rsp_ch.cell_data);
					error_count++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			gap = idle_gap();
			if (gap > 0) begin
				stall_left = gap - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.cmd        <= tcw_pkg::CMD_PUT;
		req_ch.char_code  <= '0;
		req_ch.cell_index <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= tcw_pkg::REG_BACK_COLOR;
		cfg_ch.data       <= '0;
		steady_flow  = 1'b0;
		reset_console_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_control_codes();
		test_random_text();
		test_scroll();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("requests: %0d puts, %0d clears, %0d reads, %0d unused commands",
			put_count, clear_count, read_count, unused_count);
		$display("responses checked: %0d, scrolls: %0d, color register writes: %0d",
			replies_checked, scroll_count, color_writes);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_screen_ram.sv
rtl/text_console_writer.sv
dv/text_console_writer_tb.sv
